FILE: design/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg: shared types and constants of the glyph to serpentine pixel block
// font table, queue item and generator constants used by front and back
// ----------------------------------------------------------------------------
package gsp_pkg;

  localparam int unsigned GlyphCount  = 99;
  localparam int unsigned GlyphIdxW   = $clog2(GlyphCount);
  localparam int unsigned ColsPerChar = 6;
  localparam int unsigned RowsPerCol  = 8;
  localparam int unsigned NumPixels   = ColsPerChar * RowsPerCol;
  localparam int unsigned PixIdxW     = $clog2(NumPixels);
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  // code ranges
  localparam logic [7:0] SpecialFirst = 8'd8;
  localparam logic [7:0] SpecialLast  = 8'd11;
  localparam logic [7:0] SpecialBase  = 8'd87;
  localparam logic [7:0] PrintFirst   = 8'd32;
  localparam logic [7:0] PrintLast    = 8'd130;

  // linear congruential generator
  localparam logic [31:0] LcgMul   = 32'd1664525;
  localparam logic [31:0] LcgInc   = 32'd1013904223;
  localparam logic [31:0] SeedInit = 32'd1;

  // strip geometry
  localparam logic signed [11:0] StripTop  = 12'sd255;
  localparam logic signed [11:0] ColTopRow = 12'sd15;

  typedef enum logic [1:0] {
    StepRed,
    StepGreen,
    StepBlue
  } rnd_step_e;

  // one classified character, as queued between front and back
  typedef struct packed {
    logic                   special;
    logic [NumPixels-1:0]   bitmap;   // pixel k at bit k, column major
    logic signed [5:0]      origin_x;
    logic signed [5:0]      origin_y;
    logic [7:0]             color_red;
    logic [7:0]             color_green;
    logic [7:0]             color_blue;
  } item_t;

  // one pixel write as held in the output register
  typedef struct packed {
    logic [7:0] led_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       write_enable;
    logic       last_of_char;
  } pixel_t;

  // font columns, leftmost column in the top byte
  localparam logic [39:0] GlyphRom [GlyphCount] = '{
    40'h00_00_00_00_00, 40'h00_00_BE_00_00, 40'h00_E0_00_E0_00, 40'h28_FE_28_FE_28,
    40'h4C_92_FF_92_64, 40'hC6_C8_10_26_C6, 40'h6C_92_AA_44_0A, 40'h00_00_E0_00_00,
    40'h00_38_44_82_00, 40'h00_82_44_38_00, 40'h28_10_7C_10_28, 40'h10_10_7C_10_10,
    40'h00_00_06_04_00, 40'h10_10_10_10_10, 40'h00_00_06_06_00, 40'h02_04_08_10_20,
    40'h7C_8A_92_A2_7C, 40'h00_42_FE_02_00, 40'h46_8A_92_92_62, 40'h84_82_92_B2_CC,
    40'h18_28_48_FE_08, 40'hE4_A2_A2_A2_9C, 40'h3C_52_92_92_0C, 40'h80_8E_90_A0_C0,
    40'h6C_92_92_92_6C, 40'h60_92_92_94_78, 40'h00_00_36_36_00, 40'h00_02_36_34_00,
    40'h00_10_28_44_82, 40'h28_28_28_28_28, 40'h82_44_28_10_00, 40'h40_80_9A_90_60,
    40'h4C_92_BE_82_7C, 40'h3E_48_88_48_3E, 40'hFE_92_92_92_6C, 40'h7C_82_82_82_44,
    40'hFE_82_82_82_7C, 40'hFE_92_92_92_82, 40'hFE_90_90_90_80, 40'h7C_82_82_8A_CE,
    40'hFE_10_10_10_FE, 40'h00_82_FE_82_00, 40'h04_02_82_FC_80, 40'hFE_10_28_44_82,
    40'hFE_02_02_02_02, 40'hFE_40_38_40_FE, 40'hFE_20_10_08_FE, 40'h7C_82_82_82_7C,
    40'hFE_90_90_90_60, 40'h7C_82_8A_84_7A, 40'hFE_90_98_94_62, 40'h64_92_92_92_4C,
    40'hC0_80_FE_80_C0, 40'hFC_02_02_02_FC, 40'hF8_04_02_04_F8, 40'hFC_02_1C_02_FC,
    40'hC6_28_10_28_C6, 40'hC0_20_1E_20_C0, 40'h86_9A_92_B2_C2, 40'h00_FE_82_82_00,
    40'h20_10_08_04_02, 40'h00_82_82_FE_00, 40'h20_40_80_40_20, 40'h01_01_01_01_01,
    40'h00_80_40_20_00, 40'h04_2A_2A_2A_1E, 40'hFE_12_22_22_1C, 40'h1C_22_22_22_14,
    40'h1C_22_22_12_FE, 40'h1C_2A_2A_2A_18, 40'h10_7E_90_80_40, 40'h18_25_25_25_3E,
    40'hFE_10_10_10_0E, 40'h00_12_5E_02_00, 40'h04_02_22_BC_00, 40'hFE_08_14_22_00,
    40'h00_82_FE_02_00, 40'h3E_20_18_20_3E, 40'h3E_20_20_20_1E, 40'h1C_22_22_22_1C,
    40'h3F_28_28_28_10, 40'h10_28_28_28_3F, 40'h3E_10_20_20_10, 40'h12_2A_2A_2A_04,
    40'h20_FC_22_02_04, 40'h3C_02_02_04_3E, 40'h38_04_02_04_38, 40'h3C_02_0C_02_3C,
    40'h22_14_08_14_22, 40'h39_05_05_05_3E, 40'h22_26_2A_32_22, 40'h00_10_6C_82_00,
    40'h00_00_FE_00_00, 40'h00_82_6C_10_00, 40'h20_40_30_10_20, 40'h18_44_04_44_18,
    40'h38_44_22_44_38, 40'h18_18_00_18_18, 40'h18_18_00_18_18
  };

endpackage

FILE: design/gsp_char_if.sv
// ----------------------------------------------------------------------------
// gsp_char_if: character request channel
// valid/ready handshake carrying one character, origin and color per beat
// ----------------------------------------------------------------------------
interface gsp_char_if;
  logic              valid;
  logic              ready;
  logic [7:0]        char_code;
  logic signed [5:0] origin_x;
  logic signed [5:0] origin_y;
  logic [7:0]        color_red;
  logic [7:0]        color_green;
  logic [7:0]        color_blue;

  modport source (
    output valid, char_code, origin_x, origin_y, color_red, color_green, color_blue,
    input  ready
  );

  modport sink (
    input  valid, char_code, origin_x, origin_y, color_red, color_green, color_blue,
    output ready
  );
endinterface

FILE: design/gsp_pix_if.sv
// ----------------------------------------------------------------------------
// gsp_pix_if: pixel write channel
// valid/ready handshake carrying one led write per beat
// ----------------------------------------------------------------------------
interface gsp_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       write_enable;
  logic       last_of_char;

  modport source (
    output valid, led_index, out_red, out_green, out_blue, write_enable, last_of_char,
    input  ready
  );

  modport sink (
    input  valid, led_index, out_red, out_green, out_blue, write_enable, last_of_char,
    output ready
  );
endinterface

FILE: design/gsp_front.sv
// ----------------------------------------------------------------------------
// gsp_front: character front end
// accepts character beats, classifies the code and fetches the glyph bitmap
// ----------------------------------------------------------------------------
module gsp_front (
  gsp_char_if.sink      char_i,
  input  logic          q_full_i,
  output logic          push_o,
  output gsp_pkg::item_t item_o
);

  logic                            special;
  logic                            printable;
  logic [gsp_pkg::GlyphIdxW-1:0]   glyph_idx;
  logic [39:0]                     glyph_w;
  logic [7:0]                      code_sp;
  logic [7:0]                      code_pr;
  logic [gsp_pkg::NumPixels-1:0]   bitmap;

  assign char_i.ready = !q_full_i;
  assign push_o       = char_i.valid && !q_full_i;

  always_comb begin
    special   = (char_i.char_code >= gsp_pkg::SpecialFirst) &&
                (char_i.char_code <= gsp_pkg::SpecialLast);
    printable = (char_i.char_code >= gsp_pkg::PrintFirst) &&
                (char_i.char_code <= gsp_pkg::PrintLast);
    code_sp   = char_i.char_code + gsp_pkg::SpecialBase;
    code_pr   = char_i.char_code - gsp_pkg::PrintFirst;
    if (special) begin
      glyph_idx = code_sp[gsp_pkg::GlyphIdxW-1:0];
    end else begin
      glyph_idx = code_pr[gsp_pkg::GlyphIdxW-1:0];
    end
    glyph_w = gsp_pkg::GlyphRom[glyph_idx];

    // reorder to pixel order, sixth column blank
    bitmap = '0;
    if (special || printable) begin
      for (int c = 0; c < 5; c++) begin
        bitmap[c*8 +: 8] = glyph_w[(4-c)*8 +: 8];
      end
    end

    item_o.special     = special;
    item_o.bitmap      = bitmap;
    item_o.origin_x    = char_i.origin_x;
    item_o.origin_y    = char_i.origin_y;
    item_o.color_red   = char_i.color_red;
    item_o.color_green = char_i.color_green;
    item_o.color_blue  = char_i.color_blue;
  end

endmodule

FILE: design/gsp_queue.sv
// ----------------------------------------------------------------------------
// gsp_queue: character queue
// short fifo of classified characters between front end and pixel engine
// ----------------------------------------------------------------------------
module gsp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gsp_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output gsp_pkg::item_t item_o
);

  gsp_pkg::item_t                mem_q [gsp_pkg::QueueDepth];
  logic [gsp_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [gsp_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [gsp_pkg::QueueCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == gsp_pkg::QueueCntW'(gsp_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: design/gsp_back.sv
// ----------------------------------------------------------------------------
// gsp_back: pixel engine
// walks the 48 pixels of the head character, draws random colors, registers
// ----------------------------------------------------------------------------
module gsp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           random_seed_we_i,
  input  logic [31:0]    random_seed_i,
  input  logic           item_valid_i,
  input  gsp_pkg::item_t item_i,
  output logic           pop_o,
  gsp_pix_if.source      pix_o
);

  logic [gsp_pkg::PixIdxW-1:0] pix_q, pix_d;
  gsp_pkg::rnd_step_e          step_q, step_d;
  logic [31:0]                 prng_q, prng_d;
  logic [7:0]                  rnd_red_q, rnd_green_q;
  gsp_pkg::pixel_t             out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  logic                        last_pix;
  logic                        lit;
  logic                        rnd;
  logic                        slot_free;
  logic                        emit;
  logic                        draw;
  logic [31:0]                 lcg_nxt;
  logic [7:0]                  rnd_byte;
  logic [2:0]                  col;
  logic [2:0]                  row;
  logic signed [7:0]           pos_x;
  logic signed [7:0]           pos_y;
  logic signed [11:0]          base;
  logic signed [11:0]          serp;
  logic signed [11:0]          strip_idx;
  logic                        on_strip;

  always_comb begin
    last_pix  = (pix_q == gsp_pkg::PixIdxW'(gsp_pkg::NumPixels - 1));
    lit       = item_i.bitmap[pix_q];
    rnd       = item_i.special && lit;
    slot_free = !out_valid_q || pix_o.ready;
    emit      = item_valid_i && slot_free && (!rnd || step_q == gsp_pkg::StepBlue);
    draw      = item_valid_i && rnd && (step_q != gsp_pkg::StepBlue || slot_free);
    lcg_nxt   = prng_q * gsp_pkg::LcgMul + gsp_pkg::LcgInc;
    rnd_byte  = lcg_nxt[23:16];

    // serpentine addressing, odd columns run downward
    col       = pix_q[gsp_pkg::PixIdxW-1:3];
    row       = pix_q[2:0];
    pos_x     = 8'(item_i.origin_x) + 8'(col);
    pos_y     = 8'(item_i.origin_y) + 8'(row);
    base      = {pos_x, 4'b0000};
    if (pos_x[0]) begin
      serp = base + gsp_pkg::ColTopRow - 12'(pos_y);
    end else begin
      serp = base + 12'(pos_y);
    end
    strip_idx = gsp_pkg::StripTop - serp;
    on_strip  = (strip_idx[11:8] == 4'b0000);

    out_d              = out_q;
    out_d.led_index    = on_strip ? strip_idx[7:0] : 8'd0;
    out_d.write_enable = on_strip;
    out_d.last_of_char = last_pix;
    if (rnd) begin
      out_d.out_red   = rnd_red_q;
      out_d.out_green = rnd_green_q;
      out_d.out_blue  = rnd_byte;
    end else if (lit) begin
      out_d.out_red   = item_i.color_red;
      out_d.out_green = item_i.color_green;
      out_d.out_blue  = item_i.color_blue;
    end else begin
      out_d.out_red   = 8'd0;
      out_d.out_green = 8'd0;
      out_d.out_blue  = 8'd0;
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end

    pix_d = pix_q;
    if (emit) begin
      pix_d = last_pix ? '0 : pix_q + 1'b1;
    end

    step_d = step_q;
    if (draw) begin
      unique case (step_q)
        gsp_pkg::StepRed:   step_d = gsp_pkg::StepGreen;
        gsp_pkg::StepGreen: step_d = gsp_pkg::StepBlue;
        gsp_pkg::StepBlue:  step_d = gsp_pkg::StepRed;
        default:            step_d = gsp_pkg::StepRed;
      endcase
    end

    prng_d = prng_q;
    if (random_seed_we_i) begin
      prng_d = (random_seed_i == 32'd0) ? gsp_pkg::SeedInit : random_seed_i;
    end else if (draw) begin
      prng_d = lcg_nxt;
    end

    pop_o = emit && last_pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q       <= '0;
      step_q      <= gsp_pkg::StepRed;
      prng_q      <= gsp_pkg::SeedInit;
      out_valid_q <= 1'b0;
    end else begin
      pix_q       <= pix_d;
      step_q      <= step_d;
      prng_q      <= prng_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw && step_q == gsp_pkg::StepRed) begin
      rnd_red_q <= rnd_byte;
    end
    if (draw && step_q == gsp_pkg::StepGreen) begin
      rnd_green_q <= rnd_byte;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign pix_o.valid        = out_valid_q;
  assign pix_o.led_index    = out_q.led_index;
  assign pix_o.out_red      = out_q.out_red;
  assign pix_o.out_green    = out_q.out_green;
  assign pix_o.out_blue     = out_q.out_blue;
  assign pix_o.write_enable = out_q.write_enable;
  assign pix_o.last_of_char = out_q.last_of_char;

endmodule

FILE: design/glyph_to_serpentine_pixels.sv
// ----------------------------------------------------------------------------
// glyph_to_serpentine_pixels: 5x8 font renderer for a 16x16 serpentine strip
// turns one character beat into 48 led write beats
// ----------------------------------------------------------------------------
// Each character beat (code, signed origin, color) becomes 48 pixel beats:
// six columns left to right, each as eight rows bottom to top, the sixth
// column blank. Lit pixels carry the color, unlit ones black; codes 8 to 11
// draw the smile, heart and eyes glyphs with three fresh bytes per lit
// pixel from a 32-bit LCG, and codes without a glyph come out all black.
// The strip index is 255 minus the serpentine position; off-strip pixels
// still appear, with write_enable low and led_index zero. Throughput is one
// pixel beat per cycle unless pix_o.ready stalls it; each lit pixel of a
// special glyph first spends draws on red and green, as the single LCG
// multiplier steps once per cycle. A two-entry queue between front end and
// pixel engine takes a new character while the previous one drains; with
// the engine idle, a first pixel passes the queue entry and output register.
// random_seed must be written only while idle (not enforced); zero loads one.
// ----------------------------------------------------------------------------
module glyph_to_serpentine_pixels (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        random_seed_we_i,
  input  logic [31:0] random_seed_i,
  gsp_char_if.sink    char_i,
  gsp_pix_if.source   pix_o
);

  // front end to queue
  logic           push;
  logic           q_full;
  gsp_pkg::item_t push_item;

  // queue to pixel engine
  logic           head_valid;
  logic           pop;
  gsp_pkg::item_t head_item;

  // classify code, fetch glyph columns, hold off when the queue is full
  gsp_front u_front (
    .char_i   (char_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (push_item)
  );

  // decouples character intake from pixel output
  gsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  // pixel walk, random colors and the registered output stage
  gsp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .random_seed_we_i (random_seed_we_i),
    .random_seed_i    (random_seed_i),
    .item_valid_i     (head_valid),
    .item_i           (head_item),
    .pop_o            (pop),
    .pix_o            (pix_o)
  );

endmodule
